// File: rtl/core/qr_v1_module_placer_defines.svh
// Assertion macros shared by the QR module placer RTL.
`ifndef QR_V1_MODULE_PLACER_DEFINES_SVH
`define QR_V1_MODULE_PLACER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, clocked on i_clk, off during reset.
`define QR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("qr placer: same-cycle check failed");
// Next-cycle implication, clocked on i_clk, off during reset.
`define QR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("qr placer: next-cycle check failed");
`else
`define QR_ASSERT_IMPL(label, ante, cons)
`define QR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/core/qrmp_pkg.sv
// Types, constants and walk/mask functions for the QR version-1 module placer.
package qrmp_pkg;

    localparam int SYMBOL_SIZE = 21;
    localparam int COORD_W     = 5;

    localparam logic [COORD_W-1:0] LAST_COORD  = COORD_W'(SYMBOL_SIZE - 1);
    localparam logic [COORD_W-1:0] FINDER_EDGE = 5'd8;
    localparam logic [COORD_W-1:0] FINDER_FAR  = COORD_W'(SYMBOL_SIZE - 8);
    localparam logic [COORD_W-1:0] TIMING_IDX  = 5'd6;
    localparam logic [COORD_W-1:0] SKIP_COL    = 5'd7;

    // mask formula codes
    localparam logic [2:0] MASK_RC_EVEN    = 3'd0;
    localparam logic [2:0] MASK_ROW_EVEN   = 3'd1;
    localparam logic [2:0] MASK_COL_3      = 3'd2;
    localparam logic [2:0] MASK_RC_3       = 3'd3;
    localparam logic [2:0] MASK_BLOCK      = 3'd4;
    localparam logic [2:0] MASK_PROD       = 3'd5;
    localparam logic [2:0] MASK_PROD_PAR   = 3'd6;
    localparam logic [2:0] MASK_MIXED_PAR  = 3'd7;

    typedef logic [COORD_W-1:0] t_coord;

    typedef struct packed {
        logic [7:0] codeword;
        logic       restart;
    } t_in_item;

    typedef struct packed {
        logic [4:0] module_row;
        logic [4:0] module_column;
        logic       module_value;
        logic       last_of_byte;
        logic       last_of_symbol;
    } t_out_item;

    typedef struct packed {
        t_coord row;
        t_coord col;
        logic   up;
        logic   phase;
        logic   full;
    } t_walk;

    localparam t_walk WALK_START = '{
        row:   LAST_COORD,
        col:   LAST_COORD,
        up:    1'b1,
        phase: 1'b0,
        full:  1'b0
    };

    function automatic logic is_data(t_coord r, t_coord c);
        logic ok;
        ok = 1'b1;
        if (r <= FINDER_EDGE && c <= FINDER_EDGE) ok = 1'b0;
        if (r <= FINDER_EDGE && c >= FINDER_FAR)  ok = 1'b0;
        if (r >= FINDER_FAR && c <= FINDER_EDGE)  ok = 1'b0;
        if (r == TIMING_IDX || c == TIMING_IDX)   ok = 1'b0;
        return ok;
    endfunction

    // One zigzag step; sets full when the walk runs off the left edge.
    function automatic t_walk walk_move(t_walk w);
        t_walk  n;
        t_coord dec;
        n   = w;
        dec = (w.col == SKIP_COL) ? 5'd2 : 5'd1;
        if (!w.phase) begin
            if (w.col == '0) begin
                n.full = 1'b1;
            end else begin
                n.col   = w.col - 5'd1;
                n.phase = 1'b1;
            end
        end else begin
            n.phase = 1'b0;
            if ((w.up && w.row == '0) || (!w.up && w.row >= LAST_COORD)) begin
                n.up = !w.up;
                if (w.col < dec) begin
                    n.full = 1'b1;
                end else begin
                    n.col = w.col - dec;
                end
            end else begin
                n.row = w.up ? (w.row - 5'd1) : (w.row + 5'd1);
                n.col = w.col + 5'd1;
            end
        end
        return n;
    endfunction

    // residue mod 3 of a 5-bit value: bit weights 1,2,1,2,1
    function automatic logic [1:0] mod3(t_coord v);
        logic [2:0] s;
        s = 3'(v[0]) + 3'(v[2]) + 3'(v[4]) + {2'(v[1]) + 2'(v[3]), 1'b0};
        if (s >= 3'd6) begin
            s = s - 3'd6;
        end else if (s >= 3'd3) begin
            s = s - 3'd3;
        end
        return s[1:0];
    endfunction

    // reduce a value 0..4 mod 3
    function automatic logic [1:0] fold3(logic [2:0] v);
        logic [2:0] s;
        s = (v >= 3'd3) ? (v - 3'd3) : v;
        return s[1:0];
    endfunction

    function automatic logic mask_bit(logic [2:0] sel, t_coord r, t_coord c);
        logic [1:0] rm3;
        logic [1:0] cm3;
        logic [1:0] p3;
        logic [1:0] s3;
        logic       p2;
        logic       s2;
        logic [8:0] q;
        logic       m;
        rm3 = mod3(r);
        cm3 = mod3(c);
        p3  = fold3(3'(rm3 * cm3));
        s3  = fold3(3'(rm3) + 3'(cm3));
        p2  = r[0] & c[0];
        s2  = r[0] ^ c[0];
        q   = (9'(c) * 9'd11) >> 5;   // c / 3 for c below 32
        case (sel)
            MASK_RC_EVEN:   m = !s2;
            MASK_ROW_EVEN:  m = !r[0];
            MASK_COL_3:     m = (cm3 == 2'd0);
            MASK_RC_3:      m = (s3 == 2'd0);
            MASK_BLOCK:     m = !(r[1] ^ q[0]);
            MASK_PROD:      m = !p2 && (p3 == 2'd0);
            MASK_PROD_PAR:  m = !(p2 ^ p3[0]);
            MASK_MIXED_PAR: m = !(s2 ^ p3[0]);
            default:        m = 1'b0;
        endcase
        return m;
    endfunction

endpackage

// File: rtl/core/qr_v1_module_placer.sv
// QR version-1 data module placer: zigzag walk, bit-serial placement, masking.
//
// Input channel (i_in_valid / o_in_stall, payload i_in_item): one codeword
// byte per transaction, with a restart flag that returns the walk to the
// bottom-right corner before the byte is placed.
// Output channel (o_out_valid / i_out_stall, payload o_out_item): one
// transaction per placed module: row, column, masked value, and end-of-byte
// and end-of-symbol marks. Eight transactions per byte, MSB first.
// Config: i_cfg_wr_en / i_cfg_wr_data load the 3-bit mask pattern; write it
// only while the block is idle.
// Timing: byte bits leave a shift register one per cycle while the output
// is not stalled, and the walker advances one module position per cycle
// until it reaches a free module; a bit waits while the walker steps over
// reserved positions. An accepted byte's first module waits in the pending
// registers until the walker is on the next free one, then enters the output
// register. The next byte is taken in the cycle its predecessor's last
// result enters the output register. After the 208th module the symbol is
// full: later bytes are taken and dropped until one arrives with restart set.
// Reset: walk at the bottom-right corner moving up, mask pattern 0, output
// empty. A stalled receiver holds the output register and the walker waits on the next free module.
`include "qr_v1_module_placer_defines.svh"

module qr_v1_module_placer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  qrmp_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output qrmp_pkg::t_out_item  o_out_item,
    input  logic                 i_cfg_wr_en,
    input  logic [2:0]           i_cfg_wr_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_SEND
    } t_state;

    localparam logic [2:0] LAST_BIT = 3'd7;

    t_state               r_state,     n_state;
    qrmp_pkg::t_walk      r_walk,      n_walk;
    logic [7:0]           r_bits,      n_bits;      // byte bits, MSB is the pending one
    logic [2:0]           r_k,         n_k;         // bit index within the byte
    qrmp_pkg::t_coord     r_pend_row,  n_pend_row;  // module awaiting output
    qrmp_pkg::t_coord     r_pend_col,  n_pend_col;
    logic [2:0]           r_mask,      n_mask;
    logic                 r_out_valid, n_out_valid;
    qrmp_pkg::t_out_item  r_out_item,  n_out_item;

    logic                 w_slot_free;
    logic                 w_last_send;
    logic                 w_in_acc;
    qrmp_pkg::t_walk      w_moved;
    logic                 w_moved_stop;
    qrmp_pkg::t_walk      w_base;
    qrmp_pkg::t_walk      w_base_moved;
    logic                 w_base_stop;

    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_last_send = (r_state == ST_SEND) && w_slot_free
                         && (r_k == LAST_BIT || r_walk.full);
    assign o_in_stall  = !((r_state == ST_IDLE) || w_last_send);
    assign w_in_acc    = i_in_valid && !o_in_stall;

    // walker step from the current position
    assign w_moved      = qrmp_pkg::walk_move(r_walk);
    assign w_moved_stop = w_moved.full || qrmp_pkg::is_data(w_moved.row, w_moved.col);

    // walker step from the start position of a new byte
    assign w_base       = i_in_item.restart ? qrmp_pkg::WALK_START : r_walk;
    assign w_base_moved = qrmp_pkg::walk_move(w_base);
    assign w_base_stop  = w_base_moved.full
                          || qrmp_pkg::is_data(w_base_moved.row, w_base_moved.col);

    always_comb begin
        n_state     = r_state;
        n_walk      = r_walk;
        n_bits      = r_bits;
        n_k         = r_k;
        n_pend_row  = r_pend_row;
        n_pend_col  = r_pend_col;
        n_mask      = r_mask;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_item  = r_out_item;

        unique case (r_state)
            ST_IDLE: begin
            end
            ST_WALK: begin
                // step over reserved modules until a free one or the end
                n_walk = w_moved;
                if (w_moved_stop) begin
                    n_state = ST_SEND;
                end
            end
            ST_SEND: begin
                if (w_slot_free) begin
                    n_out_valid                  = 1'b1;
                    n_out_item.module_row        = r_pend_row;
                    n_out_item.module_column     = r_pend_col;
                    n_out_item.module_value      = r_bits[7]
                        ^ qrmp_pkg::mask_bit(r_mask, r_pend_row, r_pend_col);
                    n_out_item.last_of_byte      = (r_k == LAST_BIT);
                    n_out_item.last_of_symbol    = r_walk.full;
                    if (r_k == LAST_BIT || r_walk.full) begin
                        n_state = ST_IDLE;
                    end else begin
                        // walker already sits on the next free module
                        n_k        = r_k + 3'd1;
                        n_bits     = {r_bits[6:0], 1'b0};
                        n_pend_row = r_walk.row;
                        n_pend_col = r_walk.col;
                        n_walk     = w_moved;
                        n_state    = w_moved_stop ? ST_SEND : ST_WALK;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (w_in_acc) begin
            if (w_base.full) begin
                // symbol already complete: byte dropped
                n_walk  = w_base;
                n_state = ST_IDLE;
            end else begin
                n_bits     = i_in_item.codeword;
                n_k        = '0;
                n_pend_row = w_base.row;
                n_pend_col = w_base.col;
                n_walk     = w_base_moved;
                n_state    = w_base_stop ? ST_SEND : ST_WALK;
            end
        end

        if (i_cfg_wr_en) begin
            n_mask = i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_walk      <= qrmp_pkg::WALK_START;
            r_k         <= '0;
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_walk      <= n_walk;
            r_k         <= n_k;
            r_mask      <= n_mask;
            r_out_valid <= n_out_valid;
        end
        r_bits     <= n_bits;
        r_pend_row <= n_pend_row;
        r_pend_col <= n_pend_col;
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `QR_ASSERT_IMPL(a_out_in_symbol, r_out_valid, (r_out_item.module_row <= qrmp_pkg::LAST_COORD) && (r_out_item.module_column <= qrmp_pkg::LAST_COORD))
    `QR_ASSERT_IMPL(a_end_on_byte, r_out_valid && r_out_item.last_of_symbol, r_out_item.last_of_byte)
    `QR_ASSERT_IMPL(a_send_on_free, (r_state == ST_SEND) && !r_walk.full, qrmp_pkg::is_data(r_walk.row, r_walk.col))
    `QR_ASSERT_NEXT(a_accept_starts, w_in_acc && !w_base.full, r_state != ST_IDLE)

endmodule
